@@ hdl/fdsc_pkg.sv @@
`default_nettype none
package fdsc_pkg;

  localparam int COST_BITS  = 24;
  localparam int SCALE_BITS = 16;
  localparam int SHIFT_BITS = $clog2(COST_BITS - SCALE_BITS + 1);
  localparam int SQ_BITS    = 2 * SCALE_BITS;
  localparam int LHS_BITS   = SQ_BITS + 18;
  localparam int Q2_BITS    = 9;
  localparam int OFS_BITS   = 9;
  localparam int HYP_BITS   = 17;
  localparam int RAD_BITS   = 34;

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};
  localparam logic [OFS_BITS-1:0]  OFS_ONE  = 9'd256;
  localparam logic [9:0]           OFS_NEG  = 10'h300;

  typedef enum logic [2:0] {
    MC_BLOCKED = 3'd0,
    MC_NEAR    = 3'd1,
    MC_DIAG    = 3'd2,
    MC_CUT     = 3'd3,
    MC_EDGE    = 3'd4
  } move_case_e;

  typedef struct packed {
    move_case_e           mcase;
    logic [COST_BITS-1:0] c;
    logic [COST_BITS-1:0] n;
    logic [COST_BITS-1:0] g2;
    logic [COST_BITS-1:0] quick;
  } item_t;

  typedef struct packed {
    item_t               item;
    logic [SQ_BITS-1:0]  d;
    logic [LHS_BITS-1:0] lhs;
    logic                yone;
  } ratio_in_t;

  typedef struct packed {
    item_t               item;
    logic [OFS_BITS-1:0] y;
  } hyp_in_t;

  typedef struct packed {
    item_t               item;
    logic [OFS_BITS-1:0] y;
    logic [HYP_BITS-1:0] hyp;
  } cost_in_t;

endpackage
`default_nettype wire

@@ hdl/fdsc_front.sv @@
`default_nettype none
module fdsc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] diag_step_cost_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] edge_step_cost_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] near_path_cost_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] diag_path_cost_i,
  output logic                               valid_o,
  output fdsc_pkg::ratio_in_t                data_o
);

  localparam int CB = fdsc_pkg::COST_BITS;
  localparam int SB = fdsc_pkg::SCALE_BITS;

  logic          v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [CB-1:0] c1_q, b1_q, g11_q, g21_q;
  fdsc_pkg::item_t item2_d, item2_q, item3_q, item4_q;
  logic [SB-1:0] cs3_d, ns3_d, cs3_q, ns3_q;
  logic [fdsc_pkg::SQ_BITS-1:0] cs4_q, ns4_q;
  fdsc_pkg::ratio_in_t out5_d, out5_q;

  logic          inf, near, f_inf, use_f;
  logic [CB-1:0] f, n, mn;
  logic [CB:0]   qsum;
  logic [fdsc_pkg::SHIFT_BITS-1:0] k;

  always_comb begin
    inf   = (c1_q == fdsc_pkg::COST_INF) || (b1_q == fdsc_pkg::COST_INF);
    near  = g11_q <= g21_q;
    f     = g11_q - g21_q;
    f_inf = g11_q == fdsc_pkg::COST_INF;
    use_f = !f_inf && (f <= b1_q);
    n     = use_f ? f : b1_q;
    mn    = (c1_q < b1_q) ? c1_q : b1_q;
    qsum  = {1'b0, mn} + {1'b0, g11_q};
    item2_d.c  = c1_q;
    item2_d.n  = n;
    item2_d.g2 = g21_q;
    if (inf) begin
      item2_d.mcase = fdsc_pkg::MC_BLOCKED;
      item2_d.quick = fdsc_pkg::COST_INF;
    end else if (near) begin
      item2_d.mcase = fdsc_pkg::MC_NEAR;
      item2_d.quick = (qsum >= {1'b0, fdsc_pkg::COST_INF}) ? fdsc_pkg::COST_INF
                                                            : qsum[CB-1:0];
    end else begin
      item2_d.mcase = (c1_q <= n) ? fdsc_pkg::MC_DIAG
                    : (use_f ? fdsc_pkg::MC_CUT : fdsc_pkg::MC_EDGE);
      item2_d.quick = fdsc_pkg::COST_INF;
    end
  end

  always_comb begin
    k = '0;
    for (int i = 0; i < CB - SB; i++) begin
      if (item2_q.c[SB+i]) k = fdsc_pkg::SHIFT_BITS'(i + 1);
    end
    cs3_d = SB'(item2_q.c >> k);
    ns3_d = SB'(item2_q.n >> k);
  end

  always_comb begin
    out5_d.item = item4_q;
    out5_d.d    = cs4_q - ns4_q;
    out5_d.lhs  = {ns4_q, 18'd0};
    out5_d.yone = ns4_q >= (cs4_q - ns4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= diag_step_cost_i;
    b1_q    <= edge_step_cost_i;
    g11_q   <= near_path_cost_i;
    g21_q   <= diag_path_cost_i;
    item2_q <= item2_d;
    item3_q <= item2_q;
    cs3_q   <= cs3_d;
    ns3_q   <= ns3_d;
    item4_q <= item3_q;
    cs4_q   <= cs3_q * cs3_q;
    ns4_q   <= ns3_q * ns3_q;
    out5_q  <= out5_d;
  end

  assign valid_o = v5_q;
  assign data_o  = out5_q;

endmodule
`default_nettype wire

@@ hdl/fdsc_ratio.sv @@
`default_nettype none
module fdsc_ratio (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire fdsc_pkg::ratio_in_t  data_i,
  output logic                      valid_o,
  output fdsc_pkg::hyp_in_t         data_o
);

  localparam int QB = fdsc_pkg::Q2_BITS;
  localparam int TB = 2 * QB;

  logic                v_q    [QB];
  fdsc_pkg::ratio_in_t rd_q   [QB];
  logic [QB-1:0]       q2_q   [QB];
  logic [TB-1:0]       sq_q   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int BIT = QB - 1 - j;
    logic                v_in;
    fdsc_pkg::ratio_in_t rd_in;
    logic [QB-1:0]       q2_in, cand;
    logic [TB-1:0]       sq_in, cand_sq;
    logic [fdsc_pkg::LHS_BITS-1:0] prod;

    if (j == 0) begin : g_first
      assign v_in  = valid_i;
      assign rd_in = data_i;
      assign q2_in = '0;
      assign sq_in = '0;
    end else begin : g_next
      assign v_in  = v_q[j-1];
      assign rd_in = rd_q[j-1];
      assign q2_in = q2_q[j-1];
      assign sq_in = sq_q[j-1];
    end

    always_comb begin
      cand    = q2_in | QB'(1 << BIT);
      cand_sq = sq_in + (TB'(q2_in) << (BIT + 1)) + TB'(1 << (2 * BIT));
      prod    = fdsc_pkg::LHS_BITS'(cand_sq) * fdsc_pkg::LHS_BITS'(rd_in.d);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rd_q[j] <= rd_in;
      if (prod <= rd_in.lhs) begin
        q2_q[j] <= cand;
        sq_q[j] <= cand_sq;
      end else begin
        q2_q[j] <= q2_in;
        sq_q[j] <= sq_in;
      end
    end
  end

  logic              vo_q;
  fdsc_pkg::hyp_in_t out_d, out_q;
  logic [QB:0]       inc;
  logic              full;

  always_comb begin
    inc  = {1'b0, q2_q[QB-1]} + 1'b1;
    full = rd_q[QB-1].yone
        || (rd_q[QB-1].item.mcase != fdsc_pkg::MC_CUT
            && rd_q[QB-1].item.mcase != fdsc_pkg::MC_EDGE);
    out_d.item = rd_q[QB-1].item;
    out_d.y    = full ? fdsc_pkg::OFS_ONE : inc[QB:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

@@ hdl/fdsc_hyp.sv @@
`default_nettype none
module fdsc_hyp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire fdsc_pkg::hyp_in_t  data_i,
  output logic                    valid_o,
  output fdsc_pkg::cost_in_t      data_o
);

  localparam int HB = fdsc_pkg::HYP_BITS;
  localparam int RB = fdsc_pkg::RAD_BITS;

  logic              v0_q;
  fdsc_pkg::hyp_in_t h0_q;
  logic [RB-1:0]     rad0_q;
  logic [17:0]       yy;

  assign yy = 18'(data_i.y) * 18'(data_i.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    h0_q   <= data_i;
    rad0_q <= {yy + 18'd65536, 16'd0};
  end

  logic              v_q   [HB];
  fdsc_pkg::hyp_in_t h_q   [HB];
  logic [RB-1:0]     rad_q [HB];
  logic [HB-1:0]     r_q   [HB];
  logic [RB-1:0]     sq_q  [HB];

  for (genvar j = 0; j < HB; j++) begin : g_step
    localparam int BIT = HB - 1 - j;
    logic              v_in;
    fdsc_pkg::hyp_in_t h_in;
    logic [RB-1:0]     rad_in, sq_in;
    logic [HB-1:0]     r_in;
    logic [RB:0]       cand_sq;

    if (j == 0) begin : g_first
      assign v_in   = v0_q;
      assign h_in   = h0_q;
      assign rad_in = rad0_q;
      assign r_in   = '0;
      assign sq_in  = '0;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign h_in   = h_q[j-1];
      assign rad_in = rad_q[j-1];
      assign r_in   = r_q[j-1];
      assign sq_in  = sq_q[j-1];
    end

    assign cand_sq = {1'b0, sq_in} + ((RB+1)'(r_in) << (BIT + 1))
                   + ((RB+1)'(1) << (2 * BIT));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      h_q[j]   <= h_in;
      rad_q[j] <= rad_in;
      if (cand_sq <= {1'b0, rad_in}) begin
        r_q[j]  <= r_in | HB'(1 << BIT);
        sq_q[j] <= cand_sq[RB-1:0];
      end else begin
        r_q[j]  <= r_in;
        sq_q[j] <= sq_in;
      end
    end
  end

  logic               vo_q;
  fdsc_pkg::cost_in_t out_d, out_q;
  logic [RB-1:0]      rem;

  always_comb begin
    rem        = rad_q[HB-1] - sq_q[HB-1];
    out_d.item = h_q[HB-1].item;
    out_d.y    = h_q[HB-1].y;
    out_d.hyp  = (rem > RB'(r_q[HB-1])) ? r_q[HB-1] + 1'b1 : r_q[HB-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[HB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

@@ hdl/fdsc_cost.sv @@
`default_nettype none
module fdsc_cost (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire fdsc_pkg::cost_in_t             data_i,
  output logic                                valid_o,
  output logic [fdsc_pkg::COST_BITS-1:0]      path_cost_o,
  output logic [fdsc_pkg::OFS_BITS-1:0]       offset_x_o,
  output logic signed [9:0]                   offset_y_o,
  output logic [2:0]                          move_case_o
);

  localparam int CB = fdsc_pkg::COST_BITS;
  localparam int P1 = CB + fdsc_pkg::HYP_BITS;
  localparam int P2 = CB + fdsc_pkg::OFS_BITS;

  logic                v1_q, v2_q, v3_q;
  fdsc_pkg::cost_in_t  d1_q, d2_q;
  logic [P1-1:0]       p1_q;
  logic [P2-1:0]       p2_q;
  logic [CB:0]         t1_q, t2_q;
  logic [fdsc_pkg::OFS_BITS-1:0] ycomp;
  logic [P1-1:0]       r1;
  logic [P2-1:0]       r2;
  logic [CB+1:0]       sum;

  logic [CB-1:0]       cost_d, cost_q;
  logic [fdsc_pkg::OFS_BITS-1:0] ox_d, ox_q;
  logic [9:0]          oy_d, oy_q;
  fdsc_pkg::move_case_e mc_q;

  assign ycomp = fdsc_pkg::OFS_ONE - data_i.y;
  assign r1    = p1_q + P1'(32768);
  assign r2    = p2_q + P2'(128);

  always_comb begin
    sum = (CB+2)'(t1_q) + (CB+2)'(t2_q) + (CB+2)'(d2_q.item.g2);
    ox_d = fdsc_pkg::OFS_ONE;
    oy_d = '0;
    case (d2_q.item.mcase)
      fdsc_pkg::MC_BLOCKED: begin
        cost_d = d2_q.item.quick;
        ox_d   = '0;
      end
      fdsc_pkg::MC_NEAR: begin
        cost_d = d2_q.item.quick;
      end
      fdsc_pkg::MC_DIAG, fdsc_pkg::MC_CUT: begin
        cost_d = (sum >= (CB+2)'(fdsc_pkg::COST_INF)) ? fdsc_pkg::COST_INF : sum[CB-1:0];
        oy_d   = {1'b0, d2_q.y};
      end
      fdsc_pkg::MC_EDGE: begin
        cost_d = (sum >= (CB+2)'(fdsc_pkg::COST_INF)) ? fdsc_pkg::COST_INF : sum[CB-1:0];
        ox_d   = fdsc_pkg::OFS_ONE - d2_q.y;
        oy_d   = fdsc_pkg::OFS_NEG;
      end
      default: begin
        cost_d = fdsc_pkg::COST_INF;
        ox_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q   <= data_i;
    p1_q   <= P1'(data_i.item.c) * P1'(data_i.hyp);
    p2_q   <= P2'(data_i.item.n) * P2'(ycomp);
    d2_q   <= d1_q;
    t1_q   <= r1[P1-1:16];
    t2_q   <= r2[P2-1:8];
    cost_q <= cost_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    mc_q   <= d2_q.item.mcase;
  end

  assign valid_o     = v3_q;
  assign path_cost_o = cost_q;
  assign offset_x_o  = ox_q;
  assign offset_y_o  = oy_q;
  assign move_case_o = mc_q;

endmodule
`default_nettype wire

@@ hdl/field_d_star_cell_cost.sv @@
// Field D* interpolated cost for one cell corner.
// Throughput: one transfer per cycle; busy is held low and done_o is never stalled.
// Ratio search takes one quotient bit per stage, the root one bit per stage.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
`default_nettype none
module field_d_star_cell_cost (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] diag_step_cost_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] edge_step_cost_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] near_path_cost_i,
  input  wire logic [fdsc_pkg::COST_BITS-1:0] diag_path_cost_i,
  output logic                                done_o,
  output logic [fdsc_pkg::COST_BITS-1:0]      path_cost_o,
  output logic [fdsc_pkg::OFS_BITS-1:0]       offset_x_o,
  output logic signed [9:0]                   offset_y_o,
  output logic [2:0]                          move_case_o
);

  logic                fr_valid, ra_valid, hy_valid;
  fdsc_pkg::ratio_in_t fr_data;
  fdsc_pkg::hyp_in_t   ra_data;
  fdsc_pkg::cost_in_t  hy_data;

  assign busy = 1'b0;

  fdsc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (start && !busy),
    .diag_step_cost_i (diag_step_cost_i),
    .edge_step_cost_i (edge_step_cost_i),
    .near_path_cost_i (near_path_cost_i),
    .diag_path_cost_i (diag_path_cost_i),
    .valid_o          (fr_valid),
    .data_o           (fr_data)
  );

  fdsc_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (ra_valid),
    .data_o  (ra_data)
  );

  fdsc_hyp u_hyp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ra_valid),
    .data_i  (ra_data),
    .valid_o (hy_valid),
    .data_o  (hy_data)
  );

  fdsc_cost u_cost (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (hy_valid),
    .data_i      (hy_data),
    .valid_o     (done_o),
    .path_cost_o (path_cost_o),
    .offset_x_o  (offset_x_o),
    .offset_y_o  (offset_y_o),
    .move_case_o (move_case_o)
  );

endmodule
`default_nettype wire
